### rtl/crqh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqh_pkg
// Shared types, register codes and the multiply-sequence table of the
// closest ray/quad hit unit.
// ----------------------------------------------------------------------------
package crqh_pkg;

  localparam int MulAW = 72;
  localparam int MulBW = 56;
  localparam int ProdW = MulAW + MulBW;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec3_t;

  typedef struct packed {
    logic signed [16:0] z;
    logic signed [16:0] y;
    logic signed [16:0] x;
  } dvec_t;

  typedef struct packed {
    vec3_t origin;
    vec3_t direction;
  } ray_t;

  typedef struct packed {
    logic [47:0] vertex_a;
    logic [47:0] vertex_b;
    logic [47:0] vertex_c;
    logic [47:0] vertex_d;
    logic        last_quad;
  } quad_in_t;

  typedef struct packed {
    logic        hit_found;
    logic [15:0] closest_quad;
    logic [31:0] closest_param;
  } hit_out_t;

  // e[k]: edge vector, w[k]: origin minus edge start, for edges AB, BC, CD, DA
  typedef struct packed {
    dvec_t [3:0] e;
    dvec_t [3:0] w;
    dvec_t       ac;
    logic        last;
  } qent_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5
  } cfg_reg_t;

  localparam logic signed [15:0] DirZReset = 16'sd256;

  localparam logic [4:0] STEP_DEN_LAST   = 5'd11;
  localparam logic [4:0] STEP_EDGE_FIRST = 5'd12;
  localparam logic [4:0] STEP_EDGE_LAST  = 5'd31;

  typedef enum logic [3:0] {
    A_AB0, A_AB1, A_AB2, A_N0, A_N1, A_N2, A_E0, A_E1, A_E2, A_DOT1, A_DOT2
  } asrc_t;

  typedef enum logic [4:0] {
    B_AC0, B_AC1, B_AC2, B_WA0, B_WA1, B_WA2, B_DIR0, B_DIR1, B_DIR2,
    B_W0, B_W1, B_W2, B_C10, B_C11, B_C12, B_C20, B_C21, B_C22, B_DEN, B_NUM
  } bsrc_t;

  typedef enum logic [3:0] {
    D_NONE, D_N0, D_N1, D_N2, D_NUM, D_DEN, D_C10, D_C11, D_C12,
    D_C20, D_C21, D_C22, D_DOT1, D_DOT2
  } dst_t;

  typedef struct packed {
    asrc_t a;
    bsrc_t b;
    logic  clr;
    logic  sub;
    dst_t  dst;
  } uop_t;

  function automatic dvec_t sub3(vec3_t y, vec3_t x);
    dvec_t r;
    r.x = 17'(y.x) - 17'(x.x);
    r.y = 17'(y.y) - 17'(x.y);
    r.z = 17'(y.z) - 17'(x.z);
    return r;
  endfunction

  function automatic uop_t mk(asrc_t a, bsrc_t b, logic clr, logic sub, dst_t dst);
    uop_t u;
    u.a   = a;
    u.b   = b;
    u.clr = clr;
    u.sub = sub;
    u.dst = dst;
    return u;
  endfunction

  // steps 0..11: normal, numerator, denominator; 12..31: one edge test
  function automatic uop_t crqh_uop(logic [4:0] step);
    uop_t u;
    unique case (step)
      5'd0:  u = mk(A_AB1, B_AC2,  1'b1, 1'b0, D_NONE);
      5'd1:  u = mk(A_AB2, B_AC1,  1'b0, 1'b1, D_N0);
      5'd2:  u = mk(A_AB2, B_AC0,  1'b1, 1'b0, D_NONE);
      5'd3:  u = mk(A_AB0, B_AC2,  1'b0, 1'b1, D_N1);
      5'd4:  u = mk(A_AB0, B_AC1,  1'b1, 1'b0, D_NONE);
      5'd5:  u = mk(A_AB1, B_AC0,  1'b0, 1'b1, D_N2);
      5'd6:  u = mk(A_N0,  B_WA0,  1'b1, 1'b1, D_NONE);
      5'd7:  u = mk(A_N1,  B_WA1,  1'b0, 1'b1, D_NONE);
      5'd8:  u = mk(A_N2,  B_WA2,  1'b0, 1'b1, D_NUM);
      5'd9:  u = mk(A_N0,  B_DIR0, 1'b1, 1'b0, D_NONE);
      5'd10: u = mk(A_N1,  B_DIR1, 1'b0, 1'b0, D_NONE);
      5'd11: u = mk(A_N2,  B_DIR2, 1'b0, 1'b0, D_DEN);
      5'd12: u = mk(A_E1,  B_W2,   1'b1, 1'b0, D_NONE);
      5'd13: u = mk(A_E2,  B_W1,   1'b0, 1'b1, D_C10);
      5'd14: u = mk(A_E2,  B_W0,   1'b1, 1'b0, D_NONE);
      5'd15: u = mk(A_E0,  B_W2,   1'b0, 1'b1, D_C11);
      5'd16: u = mk(A_E0,  B_W1,   1'b1, 1'b0, D_NONE);
      5'd17: u = mk(A_E1,  B_W0,   1'b0, 1'b1, D_C12);
      5'd18: u = mk(A_E1,  B_DIR2, 1'b1, 1'b0, D_NONE);
      5'd19: u = mk(A_E2,  B_DIR1, 1'b0, 1'b1, D_C20);
      5'd20: u = mk(A_E2,  B_DIR0, 1'b1, 1'b0, D_NONE);
      5'd21: u = mk(A_E0,  B_DIR2, 1'b0, 1'b1, D_C21);
      5'd22: u = mk(A_E0,  B_DIR1, 1'b1, 1'b0, D_NONE);
      5'd23: u = mk(A_E1,  B_DIR0, 1'b0, 1'b1, D_C22);
      5'd24: u = mk(A_N0,  B_C10,  1'b1, 1'b0, D_NONE);
      5'd25: u = mk(A_N1,  B_C11,  1'b0, 1'b0, D_NONE);
      5'd26: u = mk(A_N2,  B_C12,  1'b0, 1'b0, D_DOT1);
      5'd27: u = mk(A_N0,  B_C20,  1'b1, 1'b0, D_NONE);
      5'd28: u = mk(A_N1,  B_C21,  1'b0, 1'b0, D_NONE);
      5'd29: u = mk(A_N2,  B_C22,  1'b0, 1'b0, D_DOT2);
      5'd30: u = mk(A_DOT1, B_DEN, 1'b1, 1'b0, D_NONE);
      5'd31: u = mk(A_DOT2, B_NUM, 1'b0, 1'b0, D_NONE);
    endcase
    return u;
  endfunction

endpackage

### rtl/crqh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqh_front
// Input side: takes a quad and forms its edge and origin difference vectors.
// ----------------------------------------------------------------------------
module crqh_front
  import crqh_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  quad_in_t in_data,
  input  ray_t     ray,
  input  logic     q_full,
  output logic     q_push,
  output qent_t    q_entry
);

  vec3_t va, vb, vc, vd;

  assign va = vec3_t'(in_data.vertex_a);
  assign vb = vec3_t'(in_data.vertex_b);
  assign vc = vec3_t'(in_data.vertex_c);
  assign vd = vec3_t'(in_data.vertex_d);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.e[0] = sub3(vb, va);
    q_entry.e[1] = sub3(vc, vb);
    q_entry.e[2] = sub3(vd, vc);
    q_entry.e[3] = sub3(va, vd);
    q_entry.w[0] = sub3(ray.origin, va);
    q_entry.w[1] = sub3(ray.origin, vb);
    q_entry.w[2] = sub3(ray.origin, vc);
    q_entry.w[3] = sub3(ray.origin, vd);
    q_entry.ac   = sub3(vc, va);
    q_entry.last = in_data.last_quad;
  end

endmodule

### rtl/crqh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqh_fifo
// Two-entry queue between the input side and the test sequencer.
// ----------------------------------------------------------------------------
module crqh_fifo
  import crqh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output qent_t head
);

  localparam int Depth = 2;

  qent_t      mem_r [Depth];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  assign full  = (cnt_r == 2'(Depth));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_r];

endmodule

### rtl/crqh_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqh_mul
// Signed multiplier, one byte of the second operand per cycle, MSB first.
// ----------------------------------------------------------------------------
module crqh_mul
  import crqh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [MulAW-1:0] a,
  input  logic signed [MulBW-1:0] b,
  output logic                    done,
  output logic [ProdW-1:0]        p
);

  localparam int DigW   = 8;
  localparam int Digits = MulBW / DigW;
  localparam int CntW   = $clog2(Digits);
  localparam logic [CntW-1:0] CntLast = CntW'(Digits - 1);

  logic signed [MulAW-1:0]      a_r;
  logic [MulBW-1:0]             b_r;
  logic [CntW-1:0]              cnt_r;
  logic                         busy_r, done_r;
  logic [ProdW-1:0]             acc_r;
  logic signed [DigW:0]         dig;
  logic signed [MulAW+DigW:0]   pp;

  // top byte carries the sign, the rest are unsigned
  assign dig = (cnt_r == '0) ? {b_r[MulBW-1], b_r[MulBW-1 -: DigW]}
                             : {1'b0, b_r[MulBW-1 -: DigW]};
  assign pp  = a_r * dig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CntLast);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CntLast)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      cnt_r <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[ProdW-DigW-1:0], {DigW{1'b0}}} + ProdW'(pp);
      b_r   <= b_r << DigW;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

### rtl/crqh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqh_div
// |num| / |den| as unsigned Q16.16, saturating; restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module crqh_div
  import crqh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [53:0] num,
  input  logic signed [52:0] den,
  output logic               done,
  output logic [31:0]        q
);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_CHK  = 3'b010,
    DV_RUN  = 3'b100
  } dstate_t;

  dstate_t     state_r;
  logic [53:0] an_r;
  logic [52:0] ad_r;
  logic [52:0] rem_r;
  logic [31:0] low_r, q_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [53:0] trial, diff;
  logic        ge, sat;

  assign trial = {rem_r, low_r[31]};
  assign ge    = (trial >= {1'b0, ad_r});
  assign diff  = trial - {1'b0, ad_r};
  assign sat   = ({16'h0, an_r} >= {1'b0, ad_r, 16'h0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        DV_IDLE: if (start) state_r <= DV_CHK;
        DV_CHK: begin
          if (sat) begin
            state_r <= DV_IDLE;
            done_r  <= 1'b1;
          end else begin
            state_r <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (cnt_r == 5'd31) begin
            state_r <= DV_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && start) begin
      an_r <= num[53] ? 54'(-num) : 54'(num);
      ad_r <= den[52] ? 53'(-den) : 53'(den);
    end
    if (state_r == DV_CHK) begin
      q_r   <= '1;
      rem_r <= 53'(an_r[53:16]);
      low_r <= {an_r[15:0], 16'h0};
      cnt_r <= '0;
    end
    if (state_r == DV_RUN) begin
      rem_r <= ge ? 53'(diff) : 53'(trial);
      q_r   <= {q_r[30:0], ge};
      low_r <= low_r << 1;
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign done = done_r;
  assign q    = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == DV_IDLE)
    else $error("divide started while busy");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == DV_RUN |-> ad_r != '0)
    else $error("divide running with zero divisor");

endmodule

### rtl/crqh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crqh_back
// Test sequencer: runs the multiply table per quad, checks the edges,
// divides for the hit parameter and keeps the running nearest hit.
// ----------------------------------------------------------------------------
module crqh_back
  import crqh_pkg::*;
#(
  parameter int MAX_QUADS = 65536
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ray_t     ray,
  input  logic     q_valid,
  input  qent_t    q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output hit_out_t out_data
);

  localparam logic [15:0] CntLast = 16'(MAX_QUADS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ISSUE  = 6'b000010,
    S_WAIT   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]         step_r;
  logic [1:0]         side_r;
  logic [ProdW-1:0]   sum_r, sum_acc, prod, base;
  logic signed [34:0] n0_r, n1_r, n2_r, c10_r, c11_r, c12_r;
  logic signed [33:0] c20_r, c21_r, c22_r;
  logic signed [53:0] num_r;
  logic signed [52:0] den_r;
  logic signed [71:0] dot1_r;
  logic signed [70:0] dot2_r;
  logic               hit_r;
  logic [31:0]        q_r;
  logic [15:0]        cnt_r, bestq_r;
  logic [31:0]        best_r;
  logic               any_r;
  logic               out_valid_r;
  hit_out_t           out_data_r;

  uop_t                    uop;
  dvec_t                   cur_e, cur_w, ab, wa;
  logic signed [MulAW-1:0] op_a;
  logic signed [MulBW-1:0] op_b;
  logic                    mul_start, mul_done, div_start, div_done;
  logic [31:0]             div_q;
  logic                    edge_pass, out_free, upd, fin_any;
  logic [15:0]             fin_quad;
  logic [31:0]             fin_param;

  assign uop   = crqh_uop(step_r);
  assign cur_e = q_head.e[side_r];
  assign cur_w = q_head.w[side_r];
  assign ab    = q_head.e[0];
  assign wa    = q_head.w[0];

  always_comb begin
    unique case (uop.a)
      A_AB0:   op_a = MulAW'(ab.x);
      A_AB1:   op_a = MulAW'(ab.y);
      A_AB2:   op_a = MulAW'(ab.z);
      A_N0:    op_a = MulAW'(n0_r);
      A_N1:    op_a = MulAW'(n1_r);
      A_N2:    op_a = MulAW'(n2_r);
      A_E0:    op_a = MulAW'(cur_e.x);
      A_E1:    op_a = MulAW'(cur_e.y);
      A_E2:    op_a = MulAW'(cur_e.z);
      A_DOT1:  op_a = dot1_r;
      A_DOT2:  op_a = MulAW'(dot2_r);
      default: op_a = '0;
    endcase
  end

  always_comb begin
    unique case (uop.b)
      B_AC0:   op_b = MulBW'(q_head.ac.x);
      B_AC1:   op_b = MulBW'(q_head.ac.y);
      B_AC2:   op_b = MulBW'(q_head.ac.z);
      B_WA0:   op_b = MulBW'(wa.x);
      B_WA1:   op_b = MulBW'(wa.y);
      B_WA2:   op_b = MulBW'(wa.z);
      B_DIR0:  op_b = MulBW'(ray.direction.x);
      B_DIR1:  op_b = MulBW'(ray.direction.y);
      B_DIR2:  op_b = MulBW'(ray.direction.z);
      B_W0:    op_b = MulBW'(cur_w.x);
      B_W1:    op_b = MulBW'(cur_w.y);
      B_W2:    op_b = MulBW'(cur_w.z);
      B_C10:   op_b = MulBW'(c10_r);
      B_C11:   op_b = MulBW'(c11_r);
      B_C12:   op_b = MulBW'(c12_r);
      B_C20:   op_b = MulBW'(c20_r);
      B_C21:   op_b = MulBW'(c21_r);
      B_C22:   op_b = MulBW'(c22_r);
      B_DEN:   op_b = MulBW'(den_r);
      B_NUM:   op_b = MulBW'(num_r);
      default: op_b = '0;
    endcase
  end

  assign mul_start = (state_r == S_ISSUE);

  crqh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (prod)
  );

  assign base    = uop.clr ? '0 : sum_r;
  assign sum_acc = uop.sub ? base - prod : base + prod;

  // sign of den * edge test value; zero counts as inside
  assign edge_pass = den_r[52] ? (sum_r[ProdW-1] || (sum_r == '0)) : !sum_r[ProdW-1];

  assign div_start = (state_r == S_CHECK) && (step_r == STEP_EDGE_LAST) && edge_pass
                     && (&side_r);

  crqh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .q     (div_q)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == S_FINISH) && (!q_head.last || out_free);
  assign upd       = hit_r && (!any_r || (q_r < best_r));
  assign fin_any   = any_r || upd;
  assign fin_quad  = upd ? cnt_r : bestq_r;
  assign fin_param = upd ? q_r : best_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (mul_done) begin
          if (step_r == STEP_DEN_LAST || step_r == STEP_EDGE_LAST) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_CHECK: begin
        priority if (step_r == STEP_DEN_LAST) begin
          state_nxt = (den_r == '0) ? S_FINISH : S_ISSUE;
        end else if (!edge_pass) begin
          state_nxt = S_FINISH;
        end else if (&side_r) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_DIV:    if (div_done) state_nxt = S_FINISH;
      S_FINISH: if (q_pop) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      best_r      <= '1;
      bestq_r     <= '0;
      any_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_head.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_head.last) begin
          cnt_r       <= '0;
          best_r      <= '1;
          bestq_r     <= '0;
          any_r       <= 1'b0;
        end else begin
          cnt_r <= (cnt_r == CntLast) ? '0 : cnt_r + 16'd1;
          if (upd) begin
            any_r   <= 1'b1;
            best_r  <= q_r;
            bestq_r <= cnt_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      out_data_r.hit_found     <= fin_any;
      out_data_r.closest_quad  <= fin_any ? fin_quad : '0;
      out_data_r.closest_param <= fin_any ? fin_param : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      step_r <= '0;
      side_r <= '0;
    end
    if (state_r == S_WAIT && mul_done) begin
      sum_r <= sum_acc;
      if (step_r != STEP_DEN_LAST && step_r != STEP_EDGE_LAST) step_r <= step_r + 5'd1;
      unique case (uop.dst)
        D_N0:    n0_r   <= 35'(sum_acc);
        D_N1:    n1_r   <= 35'(sum_acc);
        D_N2:    n2_r   <= 35'(sum_acc);
        D_NUM:   num_r  <= 54'(sum_acc);
        D_DEN:   den_r  <= 53'(sum_acc);
        D_C10:   c10_r  <= 35'(sum_acc);
        D_C11:   c11_r  <= 35'(sum_acc);
        D_C12:   c12_r  <= 35'(sum_acc);
        D_C20:   c20_r  <= 34'(sum_acc);
        D_C21:   c21_r  <= 34'(sum_acc);
        D_C22:   c22_r  <= 34'(sum_acc);
        D_DOT1:  dot1_r <= 72'(sum_acc);
        D_DOT2:  dot2_r <= 71'(sum_acc);
        default: ;
      endcase
    end
    if (state_r == S_CHECK) begin
      hit_r  <= 1'b0;
      step_r <= STEP_EDGE_FIRST;
      if (step_r == STEP_EDGE_LAST) side_r <= side_r + 2'd1;
    end
    if (state_r == S_DIV && div_done) begin
      hit_r <= 1'b1;
      q_r   <= div_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pop_finish: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_FINISH && q_valid)
    else $error("queue popped outside finish");

  a_issue_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ISSUE |-> q_valid)
    else $error("multiply issued without an item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.last |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.last |=> !any_r && cnt_r == '0 && out_valid_r)
    else $error("state not cleared after mesh end");

endmodule

### rtl/closest_ray_quad_hit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_ray_quad_hit_unit
// Nearest hit of a configured ray over a stream of quads.
// One shared byte-serial multiplier, which forms all of a quad's products in turn, and a
// 1-bit-per-cycle divider do the arithmetic; a two-entry queue, whose head is
// the quad under test, takes the next quad meanwhile.
// Reset (synchronous, active low): ray registers to origin 0, direction +z,
// running best cleared, queue and result register empty.
// ----------------------------------------------------------------------------
module closest_ray_quad_hit_unit
  import crqh_pkg::*;
#(
  parameter int MAX_QUADS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  quad_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output hit_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ray_t  ray_r;
  logic  q_full, q_push, q_pop, q_valid;
  qent_t q_entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.origin      <= '0;
      ray_r.direction.x <= '0;
      ray_r.direction.y <= '0;
      ray_r.direction.z <= DirZReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:    ray_r.origin.x    <= cfg_wdata;
        REG_ORIGIN_Y:    ray_r.origin.y    <= cfg_wdata;
        REG_ORIGIN_Z:    ray_r.origin.z    <= cfg_wdata;
        REG_DIRECTION_X: ray_r.direction.x <= cfg_wdata;
        REG_DIRECTION_Y: ray_r.direction.y <= cfg_wdata;
        REG_DIRECTION_Z: ray_r.direction.z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crqh_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .ray      (ray_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  crqh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  crqh_back #(
    .MAX_QUADS (MAX_QUADS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### verif/tb_closest_ray_quad_hit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_ray_quad_hit_unit
// Self-checking bench for the closest ray/quad hit unit. Meshes of quads are
// streamed through the valid/stall input while the result side stalls at
// random, save in the no-idling test. A local exact-integer model of the
// intersection and running minimum predicts each end-of-mesh result. The
// ray is reprogrammed only with the block drained.
// ----------------------------------------------------------------------------
module tb_closest_ray_quad_hit_unit;
  import crqh_pkg::*;

  typedef longint v3_t [3];
  typedef logic signed [127:0] w128_t;

  localparam int unsigned CycleLimit = 4000000;
  localparam int DrainCycles = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  quad_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  hit_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  closest_ray_quad_hit_unit dut (.*);

  always #2 clk = ~clk;

  // ray copy and running best
  logic signed [15:0] ray_reg [6];
  logic [15:0] quad_ord;
  logic [31:0] best_dist;
  logic [15:0] best_ord;
  logic        seen_hit;

  hit_out_t    pending_hits [$];
  int          fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && rst_n && ($urandom_range(99) < 25);
  end

  always @(posedge clk) begin
    hit_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result transfer with nothing pending");
        fail_cnt++;
      end else begin
        want = pending_hits.pop_front();
        if (out_data.hit_found !== want.hit_found) begin
          $error("hit_found exp %0d got %0d", want.hit_found, out_data.hit_found);
          fail_cnt++;
        end
        if (out_data.closest_quad !== want.closest_quad) begin
          $error("closest_quad exp %0d got %0d", want.closest_quad, out_data.closest_quad);
          fail_cnt++;
        end
        if (out_data.closest_param !== want.closest_param) begin
          $error("closest_param exp %h got %h", want.closest_param, out_data.closest_param);
          fail_cnt++;
        end
      end
    end
  end

  function automatic v3_t unpack3(logic [47:0] v);
    v3_t r;
    r[0] = longint'($signed(v[15:0]));
    r[1] = longint'($signed(v[31:16]));
    r[2] = longint'($signed(v[47:32]));
    return r;
  endfunction

  function automatic v3_t cross3(v3_t a, v3_t b);
    v3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic w128_t dot_wide(v3_t a, v3_t b);
    w128_t s;
    s = '0;
    for (int k = 0; k < 3; k++) s += w128_t'(a[k]) * w128_t'(b[k]);
    return s;
  endfunction

  function automatic bit edge_ok(v3_t n, v3_t x, v3_t y, v3_t p, v3_t dir,
                                 longint num, longint den);
    v3_t e, w;
    w128_t g;
    for (int k = 0; k < 3; k++) begin
      e[k] = y[k] - x[k];
      w[k] = p[k] - x[k];
    end
    g = w128_t'(den) * dot_wide(n, cross3(e, w)) + w128_t'(num) * dot_wide(n, cross3(e, dir));
    if (den > 0) return g >= 0;
    return g <= 0;
  endfunction

  // one quad against the ray; updates the running best, may emit a result
  function automatic void track_quad(quad_in_t q);
    v3_t a, b, c, d, p, dir, ab, ac, n;
    longint num, den;
    logic [127:0] an, ad, ip;
    logic [31:0] param_q;
    hit_out_t res;
    a = unpack3(q.vertex_a);
    b = unpack3(q.vertex_b);
    c = unpack3(q.vertex_c);
    d = unpack3(q.vertex_d);
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'(ray_reg[k]);
      dir[k] = longint'(ray_reg[k + 3]);
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
    end
    n = cross3(ab, ac);
    num = 0;
    den = 0;
    for (int k = 0; k < 3; k++) begin
      num += n[k] * (a[k] - p[k]);
      den += n[k] * dir[k];
    end
    if (den != 0 && edge_ok(n, a, b, p, dir, num, den) && edge_ok(n, b, c, p, dir, num, den)
        && edge_ok(n, c, d, p, dir, num, den) && edge_ok(n, d, a, p, dir, num, den)) begin
      an = 128'(num < 0 ? -num : num);
      ad = 128'(den < 0 ? -den : den);
      ip = an / ad;
      param_q = (ip >= 65536) ? 32'hFFFF_FFFF : 32'((an << 16) / ad);
      if (!seen_hit || param_q < best_dist) begin
        seen_hit = 1'b1;
        best_dist = param_q;
        best_ord = quad_ord;
      end
    end
    if (q.last_quad) begin
      res.hit_found = seen_hit;
      res.closest_quad = seen_hit ? best_ord : 16'd0;
      res.closest_param = seen_hit ? best_dist : 32'd0;
      pending_hits = {pending_hits, res};
      quad_ord = '0;
      best_dist = '1;
      best_ord = '0;
      seen_hit = 1'b0;
    end else begin
      quad_ord = quad_ord + 16'd1;
    end
  endfunction

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic logic [47:0] vtx(int x, int y, int z);
    return {sat16(z), sat16(y), sat16(x)};
  endfunction

  function automatic quad_in_t square_z(int cx, int cy, int z, int h, bit last);
    quad_in_t q;
    q.vertex_a = vtx(cx - h, cy - h, z);
    q.vertex_b = vtx(cx + h, cy - h, z);
    q.vertex_c = vtx(cx + h, cy + h, z);
    q.vertex_d = vtx(cx - h, cy + h, z);
    q.last_quad = last;
    return q;
  endfunction

  function automatic int srand(int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  // parallelogram around a point on the ray, so that most of them are hit
  function automatic quad_in_t aimed_quad(bit last, int span);
    int k;
    int cen [3];
    int u [3];
    int v [3];
    quad_in_t q;
    k = srand(6);
    for (int i = 0; i < 3; i++) begin
      cen[i] = int'(ray_reg[i]) + k * int'(ray_reg[i + 3]);
      u[i] = srand(span);
      v[i] = srand(span);
    end
    q.vertex_a = vtx(cen[0] + u[0], cen[1] + u[1], cen[2] + u[2]);
    q.vertex_b = vtx(cen[0] + v[0], cen[1] + v[1], cen[2] + v[2]);
    q.vertex_c = vtx(cen[0] - u[0], cen[1] - u[1], cen[2] - u[2]);
    q.vertex_d = vtx(cen[0] - v[0], cen[1] - v[1], cen[2] - v[2]);
    q.last_quad = last;
    return q;
  endfunction

  function automatic quad_in_t noise_quad(bit last);
    quad_in_t q;
    q.vertex_a = 48'({$urandom, $urandom});
    q.vertex_b = 48'({$urandom, $urandom});
    q.vertex_c = 48'({$urandom, $urandom});
    q.vertex_d = 48'({$urandom, $urandom});
    q.last_quad = last;
    return q;
  endfunction

  // entered and left at a falling edge
  task automatic send_quad(quad_in_t q);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (in_stall);
    track_quad(q);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_reg(cfg_reg_t r, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    ray_reg[r] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    set_reg(REG_ORIGIN_X, sat16(ox));
    set_reg(REG_ORIGIN_Y, sat16(oy));
    set_reg(REG_ORIGIN_Z, sat16(oz));
    set_reg(REG_DIRECTION_X, sat16(dx));
    set_reg(REG_DIRECTION_Y, sat16(dy));
    set_reg(REG_DIRECTION_Z, sat16(dz));
  endtask

  task automatic send_mesh(int len, int span);
    quad_in_t q;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 15) q = noise_quad(i == len - 1);
      else q = aimed_quad(i == len - 1, span);
      send_quad(q);
      if (i < len - 1 && $urandom_range(99) < 10) begin
        q.last_quad = (i == len - 2);
        send_quad(q);
        i++;
      end
    end
  endtask

  task automatic test_default_ray();
    quad_in_t q;
    send_quad(square_z(0, 0, 1024, 512, 1'b0));
    send_quad(square_z(0, 0, 512, 512, 1'b0));
    send_quad(square_z(0, 0, -256, 64, 1'b1));
    send_quad(square_z(100, -100, 768, 300, 1'b0));
    send_quad(square_z(100, -100, 768, 300, 1'b1));
    q.vertex_a = vtx(-512, 0, -512);
    q.vertex_b = vtx(512, 0, -512);
    q.vertex_c = vtx(512, 0, 512);
    q.vertex_d = vtx(-512, 0, 512);
    q.last_quad = 1'b0;
    send_quad(q);
    q.vertex_a = vtx(5, 5, 5);
    q.vertex_b = q.vertex_a;
    q.vertex_c = q.vertex_a;
    q.last_quad = 1'b1;
    send_quad(q);
    send_quad(square_z(4096, 0, 256, 512, 1'b1));
    send_quad(square_z(0, 0, 300, 0, 1'b1));
    q.vertex_a = vtx(-32768, -32768, 32767);
    q.vertex_b = vtx(32767, -32768, 32767);
    q.vertex_c = vtx(32767, 32767, 32767);
    q.vertex_d = vtx(-32768, 32767, 32767);
    q.last_quad = 1'b0;
    send_quad(q);
    q.vertex_a = vtx(-32768, -32768, -32768);
    q.vertex_b = vtx(32767, -32768, -32768);
    q.vertex_c = vtx(32767, 32767, -32768);
    q.vertex_d = vtx(-32768, 32767, -32768);
    q.last_quad = 1'b1;
    send_quad(q);
    q.vertex_a = '1;
    q.vertex_b = '0;
    q.vertex_c = '1;
    q.vertex_d = '0;
    send_quad(q);
    drain();
  endtask

  task automatic test_extreme_rays();
    set_ray(-32768, 32767, -32768, 32767, -32768, 32767);
    send_mesh(3, 2048);
    send_mesh(2, 200);
    drain();
    set_ray(32767, -32768, 32767, -32768, 32767, -32768);
    send_mesh(3, 2048);
    drain();
    set_ray(0, 0, -32768, 0, 0, 1);
    send_quad(square_z(0, 0, 32767, 100, 1'b1));
    send_quad(square_z(0, 0, 32767, 100, 1'b0));
    send_quad(square_z(0, 0, 16000, 100, 1'b1));
    drain();
    set_ray(0, 0, 0, 0, 0, 0);
    send_mesh(4, 1000);
    drain();
  endtask

  task automatic test_random_rays(int items);
    int sent;
    int len;
    set_ray(srand(8192), srand(8192), srand(8192), srand(1024), srand(1024), srand(1024));
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(3) == 0) ? int'($urandom_range(1, 12)) : int'($urandom_range(1, 4));
      send_mesh(len, ($urandom_range(1) != 0) ? 4096 : 300);
      sent += len;
    end
    drain();
  endtask

  task automatic test_no_idling();
    calm = 1'b1;
    test_random_rays(60);
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 6; i++) ray_reg[i] = '0;
    ray_reg[REG_DIRECTION_Z] = DirZReset;
    quad_ord = '0;
    best_dist = '1;
    best_ord = '0;
    seen_hit = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_ray();
    test_extreme_rays();
    for (int ph = 0; ph < 5; ph++) test_random_rays(70);
    test_no_idling();
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
